// ----- rtl/bsc_pkg.sv -----
package bsc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;

    // Register reset values
    localparam logic [31:0] RST_AC1_AC2 = 32'h1F00FB00;
    localparam logic [31:0] RST_AC3_AC4 = 32'hC7008300;
    localparam logic [31:0] RST_AC5_AC6 = 32'h61005900;
    localparam logic [31:0] RST_B1_B2   = 32'h19000000;
    localparam logic [31:0] RST_MC_MD   = 32'hD1000B00;

    // Fault codes
    localparam logic [1:0] FAULT_OK  = 2'd0;
    localparam logic [1:0] FAULT_DIV = 2'd1;
    localparam logic [1:0] FAULT_SAT = 2'd2;

    // Divider defaults
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 32;
    localparam int DIV_PW = 1;

    // Words carried alongside the temperature divider
    typedef struct packed {
        logic signed [31:0] x1;
        logic [15:0]        up;
        logic               qneg;
        logic               numneg;
        logic               dz;
    } tdiv_side_t;

    // Words carried alongside the pressure divider
    typedef struct packed {
        logic signed [15:0] t;
        logic               sat;
        logic               dz;
        logic               dbl;
        logic               bz;
    } pdiv_side_t;

endpackage

// ----- rtl/bsc_div.sv -----
module bsc_div import bsc_pkg::*; #(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW,
    parameter int PW = DIV_PW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  logic [NW-1:0] in_n,
    input  logic [DW-1:0] in_d,
    input  logic [PW-1:0] in_side,
    output logic          out_v,
    output logic [NW-1:0] out_q,
    output logic [PW-1:0] out_side
);

    // One quotient bit per stage, restoring
    logic          v_reg    [NW];
    logic [NW-1:0] n_reg    [NW];
    logic [DW-1:0] r_reg    [NW];
    logic [DW-1:0] d_reg    [NW];
    logic [PW-1:0] side_reg [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_stage
            logic          v_src;
            logic [NW-1:0] n_src;
            logic [DW-1:0] r_src;
            logic [DW-1:0] d_src;
            logic [PW-1:0] side_src;
            logic [DW:0]   trial;
            logic          ge;
            logic [DW-1:0] r_next;
            logic [NW-1:0] n_next;

            if (k == 0)
            begin : g_first
                assign v_src    = in_v;
                assign n_src    = in_n;
                assign r_src    = '0;
                assign d_src    = in_d;
                assign side_src = in_side;
            end
            else
            begin : g_rest
                assign v_src    = v_reg[k-1];
                assign n_src    = n_reg[k-1];
                assign r_src    = r_reg[k-1];
                assign d_src    = d_reg[k-1];
                assign side_src = side_reg[k-1];
            end

            // Shift in the next dividend bit and try the subtraction
            always_comb
            begin
                trial  = {r_src, n_src[NW-1]};
                ge     = (trial >= {1'b0, d_src});
                r_next = ge ? DW'(trial - {1'b0, d_src}) : trial[DW-1:0];
                n_next = {n_src[NW-2:0], ge};
            end

            // Advance the stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k]    <= n_next;
                    r_reg[k]    <= r_next;
                    d_reg[k]    <= d_src;
                    side_reg[k] <= side_src;
                end
            end
        end
    endgenerate

    assign out_v    = v_reg[NW-1];
    assign out_q    = n_reg[NW-1];
    assign out_side = side_reg[NW-1];

endmodule

// ----- rtl/barometric_sensor_compensation.sv -----
// Pipelined barometric compensation: takes one raw temperature/pressure word
// per cycle while not stalled and returns compensated temperature (0.1 degC),
// pressure (Pa) and a fault code. From acceptance to out_valid a word passes
// the input register, eight arithmetic stages, a 27-stage unsigned divider on
// magnitudes for the temperature term and a 32-stage unsigned divider for the
// pressure term, then the output register. An output stall freezes the whole
// pipeline and is passed back on in_stall. Calibration registers are used
// directly by stages 1 to 7, so write them only while the pipeline is empty.
module barometric_sensor_compensation import bsc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        raw_temperature,
    input  logic [15:0]        raw_pressure,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] temperature_tenths,
    output logic [17:0]        pressure_pa,
    output logic [1:0]         fault
);

    localparam int TNW = 27;

    logic [31:0] ac1_ac2_reg, ac3_ac4_reg, ac5_ac6_reg, b1_b2_reg, mc_md_reg;
    logic        en;

    // Calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_ac2_reg <= RST_AC1_AC2;
            ac3_ac4_reg <= RST_AC3_AC4;
            ac5_ac6_reg <= RST_AC5_AC6;
            b1_b2_reg   <= RST_B1_B2;
            mc_md_reg   <= RST_MC_MD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AC1_AC2: ac1_ac2_reg <= cfg_data;
                REG_AC3_AC4: ac3_ac4_reg <= cfg_data;
                REG_AC5_AC6: ac5_ac6_reg <= cfg_data;
                REG_B1_B2:   b1_b2_reg   <= cfg_data;
                REG_MC_MD:   mc_md_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign ac1 = {{16{ac1_ac2_reg[31]}}, ac1_ac2_reg[31:16]};
    assign ac2 = {{16{ac1_ac2_reg[15]}}, ac1_ac2_reg[15:0]};
    assign ac3 = {{16{ac3_ac4_reg[31]}}, ac3_ac4_reg[31:16]};
    assign ac4 = ac3_ac4_reg[15:0];
    assign ac5 = ac5_ac6_reg[31:16];
    assign ac6 = ac5_ac6_reg[15:0];
    assign b1  = {{16{b1_b2_reg[31]}}, b1_b2_reg[31:16]};
    assign b2  = {{16{b1_b2_reg[15]}}, b1_b2_reg[15:0]};
    assign mc  = {{16{mc_md_reg[31]}}, mc_md_reg[31:16]};
    assign md  = {{16{mc_md_reg[15]}}, mc_md_reg[15:0]};

    logic out_valid_reg;

    // Freeze everything while the output word waits
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Stage 0: input register
    logic        v0_reg;
    logic [15:0] ut0_reg, up0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ut0_reg <= raw_temperature;
            up0_reg <= raw_pressure;
        end
    end

    // Stage 1: X1 = ((UT - AC6) * AC5) >> 15
    logic signed [16:0] ut_diff;
    logic signed [33:0] x1t_prod;
    logic signed [31:0] x1t_w, x1t_next;
    logic               v1_reg;
    logic signed [31:0] x1t_reg;
    logic [15:0]        up1_reg;

    always_comb
    begin
        ut_diff  = $signed({1'b0, ut0_reg}) - $signed({1'b0, ac6});
        x1t_prod = 34'(ut_diff) * $signed({18'b0, ac5});
        x1t_w    = x1t_prod[31:0];
        x1t_next = x1t_w >>> 15;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1t_reg <= x1t_next;
            up1_reg <= up0_reg;
        end
    end

    // Prepare magnitudes for MC*2048 / (X1 + MD)
    logic signed [31:0] num, den, num_abs, den_abs;
    tdiv_side_t         tside_in, tside_out;
    logic               tdv_v;
    logic [TNW-1:0]     tdv_q;

    always_comb
    begin
        num     = mc <<< 11;
        den     = x1t_reg + md;
        num_abs = num[31] ? -num : num;
        den_abs = den[31] ? -den : den;
        tside_in.x1     = x1t_reg;
        tside_in.up     = up1_reg;
        tside_in.qneg   = num[31] ^ den[31];
        tside_in.numneg = num[31];
        tside_in.dz     = (den == 32'sd0);
    end

    bsc_div #(
        .NW (TNW),
        .DW (32),
        .PW ($bits(tdiv_side_t))
    ) u_tdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (v1_reg),
        .in_n     (num_abs[TNW-1:0]),
        .in_d     (den_abs),
        .in_side  (tside_in),
        .out_v    (tdv_v),
        .out_q    (tdv_q),
        .out_side (tside_out)
    );

    // Stage 3: B5, temperature and B6
    logic signed [31:0] x2t, b5, tt, b6_next;
    logic               satt_next;
    logic signed [15:0] t_next;
    logic               v3_reg;
    logic signed [31:0] b6_reg;
    logic signed [15:0] t3_reg;
    logic               satt3_reg, dz3_reg;
    logic [15:0]        up3_reg;

    always_comb
    begin
        if (tside_out.dz)
        begin
            x2t = tside_out.numneg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else if (tside_out.qneg)
        begin
            x2t = -$signed({5'b0, tdv_q});
        end
        else
        begin
            x2t = $signed({5'b0, tdv_q});
        end
        b5        = tside_out.x1 + x2t;
        tt        = (b5 + 32'sd8) >>> 4;
        satt_next = 1'b0;
        t_next    = tt[15:0];
        if (tt > 32'sd32767)
        begin
            t_next    = 16'sh7FFF;
            satt_next = 1'b1;
        end
        else if (tt < -32'sd32768)
        begin
            t_next    = 16'sh8000;
            satt_next = 1'b1;
        end
        b6_next = b5 - 32'sd4000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= tdv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b6_reg    <= b6_next;
            t3_reg    <= t_next;
            satt3_reg <= satt_next;
            dz3_reg   <= tside_out.dz;
            up3_reg   <= tside_out.up;
        end
    end

    // Stage 4: square of B6 and the B6 products
    logic signed [31:0] sq_m, x2p_m, x1c_m;
    logic               v4_reg;
    logic signed [31:0] sq_reg, x2p4_reg, x1c4_reg;
    logic signed [15:0] t4_reg;
    logic               satt4_reg, dz4_reg;
    logic [15:0]        up4_reg;

    always_comb
    begin
        sq_m  = b6_reg * b6_reg;
        x2p_m = ac2 * b6_reg;
        x1c_m = ac3 * b6_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg    <= sq_m >>> 12;
            x2p4_reg  <= x2p_m >>> 11;
            x1c4_reg  <= x1c_m >>> 13;
            t4_reg    <= t3_reg;
            satt4_reg <= satt3_reg;
            dz4_reg   <= dz3_reg;
            up4_reg   <= up3_reg;
        end
    end

    // Stage 5: B2 and B1 terms
    logic signed [31:0] x1b_m, x2b_m;
    logic               v5_reg;
    logic signed [31:0] x1b5_reg, x2b5_reg, x2p5_reg, x1c5_reg;
    logic signed [15:0] t5_reg;
    logic               satt5_reg, dz5_reg;
    logic [15:0]        up5_reg;

    always_comb
    begin
        x1b_m = b2 * sq_reg;
        x2b_m = b1 * sq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1b5_reg  <= x1b_m >>> 11;
            x2b5_reg  <= x2b_m >>> 16;
            x2p5_reg  <= x2p4_reg;
            x1c5_reg  <= x1c4_reg;
            t5_reg    <= t4_reg;
            satt5_reg <= satt4_reg;
            dz5_reg   <= dz4_reg;
            up5_reg   <= up4_reg;
        end
    end

    // Stage 6: B3 and the X3 feeding B4
    logic signed [31:0] b3_sum, b3_next, x3b_next;
    logic               v6_reg;
    logic signed [31:0] b3_reg, x3b_reg;
    logic signed [15:0] t6_reg;
    logic               satt6_reg, dz6_reg;
    logic [15:0]        up6_reg;

    always_comb
    begin
        b3_sum   = (ac1 <<< 2) + x1b5_reg + x2p5_reg + 32'sd2;
        b3_next  = b3_sum[31] ? ((b3_sum + 32'sd3) >>> 2) : (b3_sum >>> 2);
        x3b_next = (x1c5_reg + x2b5_reg + 32'sd2) >>> 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b3_reg    <= b3_next;
            x3b_reg   <= x3b_next;
            t6_reg    <= t5_reg;
            satt6_reg <= satt5_reg;
            dz6_reg   <= dz5_reg;
            up6_reg   <= up5_reg;
        end
    end

    // Stage 7: B4 and B7
    logic [31:0] b4_off, b4_m, b7_m;
    logic        v7_reg;
    logic [31:0] b4_reg, b7_reg;
    logic signed [15:0] t7_reg;
    logic        satt7_reg, dz7_reg;

    always_comb
    begin
        b4_off = 32'(x3b_reg + 32'sd32768);
        b4_m   = {16'b0, ac4} * b4_off;
        b7_m   = ({16'b0, up6_reg} - 32'(b3_reg)) * 32'd50000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b4_reg    <= b4_m >> 15;
            b7_reg    <= b7_m;
            t7_reg    <= t6_reg;
            satt7_reg <= satt6_reg;
            dz7_reg   <= dz6_reg;
        end
    end

    // Pressure divide: B7*2 / B4, or B7 / B4 doubled afterwards
    pdiv_side_t  pside_in, pside_out;
    logic [31:0] pdiv_n;
    logic        pdv_v;
    logic [31:0] pdv_q;

    always_comb
    begin
        pdiv_n       = b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
        pside_in.t   = t7_reg;
        pside_in.sat = satt7_reg;
        pside_in.dz  = dz7_reg;
        pside_in.dbl = b7_reg[31];
        pside_in.bz  = (b4_reg == 32'd0);
    end

    bsc_div #(
        .NW (32),
        .DW (32),
        .PW ($bits(pdiv_side_t))
    ) u_pdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (v7_reg),
        .in_n     (pdiv_n),
        .in_d     (b4_reg),
        .in_side  (pside_in),
        .out_v    (pdv_v),
        .out_q    (pdv_q),
        .out_side (pside_out)
    );

    // Stage 8: raw pressure and its square and linear terms
    logic [31:0]        pq;
    logic signed [31:0] p8, pp8, x1s_m, x2l_m;
    logic               v8_reg;
    logic signed [31:0] p8_reg, x1s8_reg, x2l8_reg;
    logic signed [15:0] t8_reg;
    logic               sat8_reg, dz8_reg;

    always_comb
    begin
        pq    = pside_out.bz ? 32'hFFFFFFFF : pdv_q;
        p8    = $signed(pside_out.dbl ? {pq[30:0], 1'b0} : pq);
        pp8   = p8 >>> 8;
        x1s_m = pp8 * pp8;
        x2l_m = -32'sd7357 * p8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v8_reg <= pdv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p8_reg   <= p8;
            x1s8_reg <= x1s_m;
            x2l8_reg <= x2l_m >>> 16;
            t8_reg   <= pside_out.t;
            sat8_reg <= pside_out.sat;
            dz8_reg  <= pside_out.dz | pside_out.bz;
        end
    end

    // Stage 9: scale the square term
    logic signed [31:0] x1k_m;
    logic               v9_reg;
    logic signed [31:0] p9_reg, x1k9_reg, x2l9_reg;
    logic signed [15:0] t9_reg;
    logic               sat9_reg, dz9_reg;

    assign x1k_m = x1s8_reg * 32'sd3038;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p9_reg   <= p8_reg;
            x1k9_reg <= x1k_m >>> 16;
            x2l9_reg <= x2l8_reg;
            t9_reg   <= t8_reg;
            sat9_reg <= sat8_reg;
            dz9_reg  <= dz8_reg;
        end
    end

    // Stage 10: final pressure, clamp and fault into the output word
    logic signed [31:0] pf;
    logic [17:0]        p_next;
    logic               satp;
    logic [1:0]         fault_next;
    logic signed [15:0] t_out_reg;
    logic [17:0]        p_out_reg;
    logic [1:0]         fault_reg;

    always_comb
    begin
        pf     = p9_reg + ((x1k9_reg + x2l9_reg + 32'sd3791) >>> 4);
        satp   = 1'b0;
        p_next = pf[17:0];
        if (pf < 32'sd0)
        begin
            p_next = '0;
            satp   = 1'b1;
        end
        else if (pf > 32'sd262143)
        begin
            p_next = '1;
            satp   = 1'b1;
        end
        if (dz9_reg)
        begin
            fault_next = FAULT_DIV;
        end
        else if (sat9_reg || satp)
        begin
            fault_next = FAULT_SAT;
        end
        else
        begin
            fault_next = FAULT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_out_reg <= t9_reg;
            p_out_reg <= p_next;
            fault_reg <= fault_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign temperature_tenths = t_out_reg;
    assign pressure_pa        = p_out_reg;
    assign fault              = fault_reg;

endmodule
